// ===== design/pvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pvc_pkg;

  // Field and register widths.
  localparam int unsigned ValW   = 32;
  localparam int unsigned GainW  = 16;
  localparam int unsigned PackW  = 48;
  localparam int unsigned DtW    = 16;
  localparam int unsigned LimW   = 31;
  localparam int unsigned NumIn  = 11;
  localparam int unsigned NumOut = 4;
  localparam int unsigned InW    = NumIn * ValW;
  localparam int unsigned OutW   = NumOut * ValW;
  localparam int unsigned IdxW   = 3;

  // Register indexes on the configuration port.
  localparam logic [IdxW-1:0] RegPosP   = 3'd0;
  localparam logic [IdxW-1:0] RegPosI   = 3'd1;
  localparam logic [IdxW-1:0] RegPosD   = 3'd2;
  localparam logic [IdxW-1:0] RegYawP   = 3'd3;
  localparam logic [IdxW-1:0] RegYawD   = 3'd4;
  localparam logic [IdxW-1:0] RegTick   = 3'd5;
  localparam logic [IdxW-1:0] RegIntLim = 3'd6;

  // Reset values of the registers that do not reset to zero.
  localparam logic [DtW-1:0]  TickReset   = 16'd655;
  localparam logic [LimW-1:0] IntLimReset = 31'd327680;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic                   done;
    logic signed [ValW-1:0] result;
  } lane_stat_t;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
    logic [DtW-1:0]          dt;
    logic [LimW-1:0]         lim;
  } lane_cfg_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [ValW-1:0] sat32(input logic signed [43:0] v);
    logic signed [ValW-1:0] r;
    if (v > 44'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -44'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[ValW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/position_pid_yaw_pd_velocity_cmd.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Three-axis position PID with clamped integrals and a yaw PD, giving a velocity and
// yaw-rate command in signed Q15.16. Four lanes work side by side on one transfer: one
// per position axis and one for yaw, each with a single shared 33 x 17 bit multiplier
// that forms, in turn, the integral increment and the P, I and D products. A merging
// stage collects the four results into an output register. s_axis_tready stays low from
// acceptance until the item's result is loaded into the output register, so a new item
// is taken only after the last one is through its lane states. A finished result
// waits in the output register while the next item is already accepted. The user must
// write gains, tick interval and integral limit through the configuration port only
// while the block is idle; the block itself does not enforce this. A register index
// of seven is ignored.

module position_pid_yaw_pd_velocity_cmd (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Input fields from bit 0 up: ref_pos_x, ref_pos_y, ref_pos_z, ref_vel_x, ref_vel_y,
  // ref_vel_z, ref_yaw, meas_pos_x, meas_pos_y, meas_pos_z, meas_yaw (32 bits each).
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [pvc_pkg::InW-1:0]     s_axis_tdata,
  // Output fields from bit 0 up: cmd_vel_x, cmd_vel_y, cmd_vel_z, cmd_yaw_rate.
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [pvc_pkg::OutW-1:0]         m_axis_tdata,
  input  wire logic                        cfg_we_i,
  input  wire logic [pvc_pkg::IdxW-1:0]    cfg_idx_i,
  input  wire logic [pvc_pkg::PackW-1:0]   cfg_data_i
);

  // Configuration registers.
  logic [pvc_pkg::PackW-1:0] pos_p_q, pos_i_q, pos_d_q;
  logic [pvc_pkg::GainW-1:0] yaw_p_q, yaw_d_q;
  logic [pvc_pkg::DtW-1:0]   tick_q;
  logic [pvc_pkg::LimW-1:0]  lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_p_q <= '0;
      pos_i_q <= '0;
      pos_d_q <= '0;
      yaw_p_q <= '0;
      yaw_d_q <= '0;
      tick_q  <= pvc_pkg::TickReset;
      lim_q   <= pvc_pkg::IntLimReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pvc_pkg::RegPosP:   pos_p_q <= cfg_data_i;
        pvc_pkg::RegPosI:   pos_i_q <= cfg_data_i;
        pvc_pkg::RegPosD:   pos_d_q <= cfg_data_i;
        pvc_pkg::RegYawP:   yaw_p_q <= cfg_data_i[pvc_pkg::GainW-1:0];
        pvc_pkg::RegYawD:   yaw_d_q <= cfg_data_i[pvc_pkg::GainW-1:0];
        pvc_pkg::RegTick:   tick_q  <= cfg_data_i[pvc_pkg::DtW-1:0];
        pvc_pkg::RegIntLim: lim_q   <= cfg_data_i[pvc_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  // The accepted transfer is held here while the lanes work on it.
  logic [pvc_pkg::InW-1:0] in_q;
  logic                    busy_q;
  logic                    accept;
  logic                    ack;
  pvc_pkg::lane_ctrl_t     ctrl;
  pvc_pkg::lane_stat_t     stat [4];

  assign s_axis_tready = ~busy_q;
  assign accept        = s_axis_tvalid & ~busy_q;
  assign ctrl.start    = accept;
  assign ctrl.ack      = ack;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (ack) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= s_axis_tdata;
    end
  end

  // Position lanes: x, y and z.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    pvc_pkg::lane_cfg_t cfg;

    assign cfg.kp  = $signed(pos_p_q[pvc_pkg::GainW*a +: pvc_pkg::GainW]);
    assign cfg.ki  = $signed(pos_i_q[pvc_pkg::GainW*a +: pvc_pkg::GainW]);
    assign cfg.kd  = $signed(pos_d_q[pvc_pkg::GainW*a +: pvc_pkg::GainW]);
    assign cfg.dt  = tick_q;
    assign cfg.lim = lim_q;

    pvc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .cfg_i      (cfg),
      .ref_pos_i  ($signed(in_q[pvc_pkg::ValW*a +: pvc_pkg::ValW])),
      .meas_pos_i ($signed(in_q[pvc_pkg::ValW*(7+a) +: pvc_pkg::ValW])),
      .ref_vel_i  ($signed(in_q[pvc_pkg::ValW*(3+a) +: pvc_pkg::ValW])),
      .stat_o     (stat[a])
    );
  end

  // The yaw lane is a PD: with no integral gain and a zero limit its integral stays
  // at zero, and it has no feedforward term.
  pvc_pkg::lane_cfg_t yaw_cfg;

  assign yaw_cfg.kp  = $signed(yaw_p_q);
  assign yaw_cfg.ki  = '0;
  assign yaw_cfg.kd  = $signed(yaw_d_q);
  assign yaw_cfg.dt  = tick_q;
  assign yaw_cfg.lim = '0;

  pvc_lane u_yaw_lane (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_i      (yaw_cfg),
    .ref_pos_i  ($signed(in_q[pvc_pkg::ValW*6 +: pvc_pkg::ValW])),
    .meas_pos_i ($signed(in_q[pvc_pkg::ValW*10 +: pvc_pkg::ValW])),
    .ref_vel_i  ('0),
    .stat_o     (stat[3])
  );

  pvc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stat_x_i      (stat[0]),
    .stat_y_i      (stat[1]),
    .stat_z_i      (stat[2]),
    .stat_yaw_i    (stat[3]),
    .ack_o         (ack),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== design/pvc_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pvc_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pvc_pkg::lane_ctrl_t         ctrl_i,
  input  wire pvc_pkg::lane_cfg_t          cfg_i,
  input  wire logic signed [31:0]          ref_pos_i,
  input  wire logic signed [31:0]          meas_pos_i,
  input  wire logic signed [31:0]          ref_vel_i,
  output pvc_pkg::lane_stat_t              stat_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StErr  = 4'd1;
  localparam logic [3:0] StMdt  = 4'd2;
  localparam logic [3:0] StInt  = 4'd3;
  localparam logic [3:0] StMi   = 4'd4;
  localparam logic [3:0] StMd   = 4'd5;
  localparam logic [3:0] StSum  = 4'd6;
  localparam logic [3:0] StOut  = 4'd7;
  localparam logic [3:0] StDone = 4'd8;

  logic [3:0]         state_q, state_d;
  logic signed [31:0] err_q, prev_q, integ_q, res_q;
  logic signed [32:0] diff_q;
  logic signed [49:0] prod_q;
  logic signed [50:0] acc_q;

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [32:0] pos_diff;
  logic signed [31:0] err_new;
  logic signed [49:0] inc_rnd;
  logic signed [34:0] integ_sum;
  logic signed [34:0] lim_s;
  logic signed [31:0] integ_new;
  logic signed [50:0] acc_rnd;
  logic signed [43:0] cmd_sum;

  // One shared multiplier; the state picks its operands.
  always_comb begin
    case (state_q)
      StMdt: begin
        mul_a = 33'(err_q);
        mul_b = $signed({1'b0, cfg_i.dt});
      end
      StMi: begin
        mul_a = 33'(integ_q);
        mul_b = 17'(cfg_i.ki);
      end
      StMd: begin
        mul_a = diff_q;
        mul_b = 17'(cfg_i.kd);
      end
      default: begin
        mul_a = 33'(err_q);
        mul_b = 17'(cfg_i.kp);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign pos_diff = 33'(ref_pos_i) - 33'(meas_pos_i);
  assign err_new  = pvc_pkg::sat32(44'(pos_diff));

  // Integral increment, rounded to nearest with ties upwards, then clamped.
  assign inc_rnd   = prod_q + 50'sd32768;
  assign integ_sum = 35'(integ_q) + 35'($signed(inc_rnd[49:16]));
  assign lim_s     = $signed({4'b0000, cfg_i.lim});

  always_comb begin
    if (integ_sum > lim_s) begin
      integ_new = lim_s[31:0];
    end else if (integ_sum < -lim_s) begin
      integ_new = 32'(-lim_s);
    end else begin
      integ_new = integ_sum[31:0];
    end
  end

  assign acc_rnd = acc_q + 51'sd128;
  assign cmd_sum = 44'($signed(acc_rnd[50:8])) + 44'(ref_vel_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (ctrl_i.start) state_d = StErr;
      StErr:  state_d = StMdt;
      StMdt:  state_d = StInt;
      StInt:  state_d = StMi;
      StMi:   state_d = StMd;
      StMd:   state_d = StSum;
      StSum:  state_d = StOut;
      StOut:  state_d = StDone;
      StDone: if (ctrl_i.ack) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      prev_q  <= '0;
      integ_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StInt) begin
        integ_q <= integ_new;
        prev_q  <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StErr: err_q <= err_new;
      StMdt: begin
        prod_q <= mul_p;
        diff_q <= 33'(err_q) - 33'(prev_q);
      end
      StInt: prod_q <= mul_p;
      StMi: begin
        acc_q  <= 51'(prod_q);
        prod_q <= mul_p;
      end
      StMd: begin
        acc_q  <= acc_q + 51'(prod_q);
        prod_q <= mul_p;
      end
      StSum: acc_q <= acc_q + 51'(prod_q);
      StOut: res_q <= pvc_pkg::sat32(cmd_sum);
      default: ;
    endcase
  end

  assign stat_o.done   = (state_q == StDone);
  assign stat_o.result = res_q;

endmodule

`default_nettype wire

// ===== design/pvc_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pvc_merge (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pvc_pkg::lane_stat_t   stat_x_i,
  input  wire pvc_pkg::lane_stat_t   stat_y_i,
  input  wire pvc_pkg::lane_stat_t   stat_z_i,
  input  wire pvc_pkg::lane_stat_t   stat_yaw_i,
  output logic                       ack_o,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [pvc_pkg::OutW-1:0]   m_axis_tdata
);

  logic                     vld_q;
  logic [pvc_pkg::OutW-1:0] data_q;
  logic                     all_done;

  assign all_done = stat_x_i.done & stat_y_i.done & stat_z_i.done & stat_yaw_i.done;
  assign ack_o    = all_done & (~vld_q | m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ack_o) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack_o) begin
      data_q <= {stat_yaw_i.result, stat_z_i.result, stat_y_i.result, stat_x_i.result};
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;

endmodule

`default_nettype wire

// ===== design/pvc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pvc_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [pvc_pkg::OutW-1:0]  m_axis_tdata
);

  // A result waiting for its consumer holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  // One item at a time: an accepted transfer closes the input side.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  // A new result only comes out of work in progress.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without an item in progress");

  // Work does not finish at once: the input stays closed while the lane states run.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 !s_axis_tready)
    else $error("item finished too early");

endmodule

bind position_pid_yaw_pd_velocity_cmd pvc_checker u_pvc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/sv/tb_position_pid_yaw_pd_velocity_cmd.sv =====
`timescale 1ns / 1ps

module tb_position_pid_yaw_pd_velocity_cmd;

  import pvc_pkg::*;

  // The upper register index is not decoded by the block; writes to it must be ignored.
  localparam logic [IdxW-1:0] RegUnused = 3'd7;

  // Cycles without any transfer or register write before the run is declared hung. The
  // longest legitimate quiet stretch is the deliberate receiver hold-off below.
  localparam int WatchdogLimit = 5000;
  localparam int HoldOffCycles = 500;
  // Quiet cycles after the last command has arrived.
  localparam int SettleCycles  = 12;
  localparam int ItemsPerPhase = 205;
  localparam int NumPhases     = 8;

  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -64'sd2147483648;

  typedef enum {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_t;
  typedef enum {CfgRandom, CfgHigh, CfgLow, CfgNoIntegral} cfg_sel_t;

  // One control tick as it travels on s_axis_tdata. A packed struct puts its first member
  // in the top bits, so the members are listed from the highest field down to ref_pos_x.
  typedef struct packed {
    logic signed [ValW-1:0] meas_yaw;
    logic signed [ValW-1:0] meas_pos_z;
    logic signed [ValW-1:0] meas_pos_y;
    logic signed [ValW-1:0] meas_pos_x;
    logic signed [ValW-1:0] ref_yaw;
    logic signed [ValW-1:0] ref_vel_z;
    logic signed [ValW-1:0] ref_vel_y;
    logic signed [ValW-1:0] ref_vel_x;
    logic signed [ValW-1:0] ref_pos_z;
    logic signed [ValW-1:0] ref_pos_y;
    logic signed [ValW-1:0] ref_pos_x;
  } ctrl_tick_t;

  // One velocity command as it travels on m_axis_tdata, again highest field first.
  typedef struct packed {
    logic signed [ValW-1:0] cmd_yaw_rate;
    logic signed [ValW-1:0] cmd_vel_z;
    logic signed [ValW-1:0] cmd_vel_y;
    logic signed [ValW-1:0] cmd_vel_x;
  } vel_cmd_t;

  // The scoreboard keeps its own copy of the gains and of the controller state. Each
  // accepted tick is run through the PID and PD laws at once, and the command that the
  // block ought to send back is queued until the real one arrives.
  class vel_cmd_scoreboard;
    logic [PackW-1:0]        kp_pack, ki_pack, kd_pack;
    logic signed [GainW-1:0] yaw_kp, yaw_kd;
    logic [DtW-1:0]          tick;
    logic [LimW-1:0]         int_lim;
    longint                  integral[3];
    longint                  last_err[3];
    longint                  last_yaw_err;
    vel_cmd_t                expected_cmds[$];
    int                      errors;

    function new();
      int a;
      kp_pack = '0;
      ki_pack = '0;
      kd_pack = '0;
      yaw_kp = '0;
      yaw_kd = '0;
      tick = TickReset;
      int_lim = IntLimReset;
      for (a = 0; a < 3; a++) begin
        integral[a] = 0;
        last_err[a] = 0;
      end
      last_yaw_err = 0;
      errors = 0;
    endfunction

    // Right shift that rounds to nearest, with ties going towards plus infinity.
    function longint round_shift(longint v, int unsigned s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip32(longint v);
      if (v > SatHi) begin
        return SatHi;
      end
      if (v < SatLo) begin
        return SatLo;
      end
      return v;
    endfunction

    function longint gain_at(logic [PackW-1:0] packed_gains, int axis);
      logic signed [GainW-1:0] g;
      g = packed_gains[16*axis +: 16];
      return g;
    endfunction

    // Bits above each register's width are dropped, just as the block drops them.
    function void write_reg(logic [IdxW-1:0] idx, logic [PackW-1:0] value);
      case (idx)
        RegPosP:   kp_pack = value;
        RegPosI:   ki_pack = value;
        RegPosD:   kd_pack = value;
        RegYawP:   yaw_kp = value[GainW-1:0];
        RegYawD:   yaw_kd = value[GainW-1:0];
        RegTick:   tick = value[DtW-1:0];
        RegIntLim: int_lim = value[LimW-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(ctrl_tick_t t);
      longint   pos_ref[3];
      longint   vel_ref[3];
      longint   pos_meas[3];
      longint   cmd[4];
      longint   dt, lim, err, diff, integ, acc, yaw_err;
      int       a;
      vel_cmd_t exp_cmd;
      pos_ref = '{t.ref_pos_x, t.ref_pos_y, t.ref_pos_z};
      vel_ref = '{t.ref_vel_x, t.ref_vel_y, t.ref_vel_z};
      pos_meas = '{t.meas_pos_x, t.meas_pos_y, t.meas_pos_z};
      dt = tick;
      lim = int_lim;
      for (a = 0; a < 3; a++) begin
        err = clip32(pos_ref[a] - pos_meas[a]);
        diff = err - last_err[a];
        // A zero tick adds nothing, and a zero limit pins the integral at zero.
        integ = integral[a] + round_shift(err * dt, 16);
        if (integ > lim) begin
          integ = lim;
        end
        if (integ < -lim) begin
          integ = -lim;
        end
        integral[a] = integ;
        acc = gain_at(kp_pack, a) * err + gain_at(ki_pack, a) * integ
            + gain_at(kd_pack, a) * diff;
        cmd[a] = clip32(vel_ref[a] + round_shift(acc, 8));
        last_err[a] = err;
      end
      // The yaw error is taken as it stands; no wrap to a half turn.
      yaw_err = clip32(longint'(t.ref_yaw) - longint'(t.meas_yaw));
      acc = longint'(yaw_kp) * yaw_err + longint'(yaw_kd) * (yaw_err - last_yaw_err);
      cmd[3] = clip32(round_shift(acc, 8));
      last_yaw_err = yaw_err;
      exp_cmd.cmd_vel_x = cmd[0][31:0];
      exp_cmd.cmd_vel_y = cmd[1][31:0];
      exp_cmd.cmd_vel_z = cmd[2][31:0];
      exp_cmd.cmd_yaw_rate = cmd[3][31:0];
      expected_cmds.push_back(exp_cmd);
    endfunction

    function void check_cmd(vel_cmd_t got);
      vel_cmd_t               want;
      logic signed [ValW-1:0] w[4];
      logic signed [ValW-1:0] g[4];
      string                  names[4];
      int                     k;
      if (expected_cmds.size() == 0) begin
        errors++;
        $error("velocity command %h arrived with no tick outstanding", got);
        return;
      end
      want = expected_cmds.pop_front();
      w = '{want.cmd_vel_x, want.cmd_vel_y, want.cmd_vel_z, want.cmd_yaw_rate};
      g = '{got.cmd_vel_x, got.cmd_vel_y, got.cmd_vel_z, got.cmd_yaw_rate};
      names = '{"cmd_vel_x", "cmd_vel_y", "cmd_vel_z", "cmd_yaw_rate"};
      for (k = 0; k < 4; k++) begin
        if (w[k] !== g[k]) begin
          errors++;
          $error("%s: expected %0d, actual %0d", names[k], w[k], g[k]);
        end
      end
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [InW-1:0]   s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OutW-1:0]  m_axis_tdata;
  logic             cfg_we_i = 1'b0;
  logic [IdxW-1:0]  cfg_idx_i = '0;
  logic [PackW-1:0] cfg_data_i = '0;

  vel_cmd_scoreboard sb = new();

  // Percentages of idle cycles on each side, and the hold-off request count. The
  // receiver compares the request count with the last one it has seen, so the main
  // sequence can ask for a hold-off without touching the receiver's own counter.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  position_pid_yaw_pd_velocity_cmd dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver side. A hold-off keeps tready low for a long stretch so that a result sits
  // in the output register, the next tick is taken behind it, and the block then has to
  // refuse further input while the sender keeps offering.
  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HoldOffCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Both transfers are sampled at the clock edge, before any of this edge's updates take
  // effect. A command is checked before the tick of the same edge is noted, although the
  // latency means the two can never belong to each other.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_cmd(vel_cmd_t'(m_axis_tdata));
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_tick(ctrl_tick_t'(s_axis_tdata));
      end
    end
  end

  // Watchdog on progress: any transfer or register write restarts the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Values that lean towards the extremes and towards small magnitudes, with plenty of
  // full-width random words so that every bit of every field toggles.
  function automatic logic signed [ValW-1:0] rand_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $signed($urandom_range(2097151)) - 32'sd1048576;
    endcase
  endfunction

  // Measurements mostly sit within one unit of the reference, as in closed-loop use,
  // which keeps the integrals away from their clamps for part of the time.
  function automatic logic signed [ValW-1:0] near(logic signed [ValW-1:0] v);
    if ($urandom_range(9) < 7) begin
      return v + ($signed($urandom_range(131071)) - 32'sd65536);
    end
    return rand_value();
  endfunction

  function automatic ctrl_tick_t rand_tick();
    ctrl_tick_t t;
    t.ref_pos_x = rand_value();
    t.ref_pos_y = rand_value();
    t.ref_pos_z = rand_value();
    t.ref_vel_x = rand_value();
    t.ref_vel_y = rand_value();
    t.ref_vel_z = rand_value();
    t.ref_yaw = rand_value();
    t.meas_pos_x = near(t.ref_pos_x);
    t.meas_pos_y = near(t.ref_pos_y);
    t.meas_pos_z = near(t.ref_pos_z);
    t.meas_yaw = near(t.ref_yaw);
    return t;
  endfunction

  // A tick with the same values on all three axes, for the directed part.
  function automatic ctrl_tick_t mk_tick(logic signed [ValW-1:0] pos_ref,
                                         logic signed [ValW-1:0] vel_ref,
                                         logic signed [ValW-1:0] yaw_ref,
                                         logic signed [ValW-1:0] pos_meas,
                                         logic signed [ValW-1:0] yaw_meas);
    ctrl_tick_t t;
    t.ref_pos_x = pos_ref;
    t.ref_pos_y = pos_ref;
    t.ref_pos_z = pos_ref;
    t.ref_vel_x = vel_ref;
    t.ref_vel_y = vel_ref;
    t.ref_vel_z = vel_ref;
    t.ref_yaw = yaw_ref;
    t.meas_pos_x = pos_meas;
    t.meas_pos_y = pos_meas;
    t.meas_pos_z = pos_meas;
    t.meas_yaw = yaw_meas;
    return t;
  endfunction

  function automatic logic [GainW-1:0] rand_gain();
    case ($urandom_range(5))
      0:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
      1, 2:    return 16'($urandom);
      default: return 16'($urandom_range(1023) - 512);
    endcase
  endfunction

  // One register write. Bits above the register's width carry noise, which the block
  // has to discard.
  task automatic write_reg(logic [IdxW-1:0] idx, logic [PackW-1:0] value, int width);
    logic [PackW-1:0] mask;
    logic [PackW-1:0] noise;
    mask = (48'd1 << width) - 48'd1;
    noise = 48'({$urandom, $urandom});
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= (noise & ~mask) | (value & mask);
    @(posedge clk_i);
    sb.write_reg(idx, (noise & ~mask) | (value & mask));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(cfg_sel_t sel);
    logic [PackW-1:0] p, i, d;
    logic [GainW-1:0] yp, yd;
    logic [DtW-1:0]   dt;
    logic [LimW-1:0]  lim;
    p = {rand_gain(), rand_gain(), rand_gain()};
    i = {rand_gain(), rand_gain(), rand_gain()};
    d = {rand_gain(), rand_gain(), rand_gain()};
    yp = rand_gain();
    yd = rand_gain();
    dt = 16'($urandom_range(65535, 1));
    lim = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(1 << 20));
    case (sel)
      CfgHigh: begin
        p = {3{16'h7fff}};
        i = {3{16'h7fff}};
        d = {3{16'h7fff}};
        yp = 16'h7fff;
        yd = 16'h7fff;
        dt = 16'hffff;
        lim = 31'h7fffffff;
      end
      CfgLow: begin
        // Most negative gains, and a zero tick that freezes the integrals.
        p = {3{16'h8000}};
        i = {3{16'h8000}};
        d = {3{16'h8000}};
        yp = 16'h8000;
        yd = 16'h8000;
        dt = '0;
        lim = 31'h7fffffff;
      end
      CfgNoIntegral: lim = '0;
      default: ;
    endcase
    write_reg(RegPosP, p, PackW);
    write_reg(RegPosI, i, PackW);
    write_reg(RegPosD, d, PackW);
    write_reg(RegYawP, yp, GainW);
    write_reg(RegYawD, yd, GainW);
    write_reg(RegTick, dt, DtW);
    write_reg(RegIntLim, lim, LimW);
    write_reg(RegUnused, 48'({$urandom, $urandom}), PackW);
  endtask

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IdleSender: begin
        send_idle_pct = 56;
        recv_stall_pct <= 0;
      end
      IdleReceiver: begin
        send_idle_pct = 0;
        recv_stall_pct <= 56;
      end
      IdleBoth: begin
        send_idle_pct = 14;
        recv_stall_pct <= 14;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
    endcase
  endtask

  // Offers one tick and returns at the edge where it is taken. A gap lowers tvalid once
  // per cycle; back-to-back ticks keep it high, so no step sees it both lowered and raised.
  task automatic send_tick(ctrl_tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= t;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
  endtask

  // Drops tvalid after the last tick and waits until every command has come back. The
  // first edge lets the monitor note the final tick before the queue is looked at.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_directed();
    int n;
    set_idle(IdleNone);
    // With the reset gains the commands are the feedforward velocity alone, while the
    // integrals already build up under the reset tick and limit.
    send_tick(mk_tick(32'sd655360, 32'sd65536, 32'sd0, 32'sd0, 32'sd0));
    send_tick(mk_tick(32'sh7fffffff, -32'sd65536, 32'sd0, 32'sh80000000, 32'sd0));
    send_tick(mk_tick(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
    drain();
    write_reg(RegPosP, {16'sd512, -16'sd128, 16'sd256}, PackW);
    write_reg(RegPosI, {-16'sd256, 16'sd256, 16'sd256}, PackW);
    write_reg(RegPosD, {16'sd64, 16'sd1, -16'sd64}, PackW);
    write_reg(RegYawP, 16'sd300, GainW);
    write_reg(RegYawD, -16'sd200, GainW);
    // Half-second tick: odd errors make the integral increment land exactly on a half.
    write_reg(RegTick, 16'd32768, DtW);
    write_reg(RegIntLim, IntLimReset, LimW);
    send_tick(mk_tick(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
    send_tick(mk_tick(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh7fffffff));
    send_tick(mk_tick(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                      32'sh80000000));
    // Position errors that saturate, with the feedforward pushing the sum over the top.
    send_tick(mk_tick(32'sh7fffffff, 32'sh7fffffff, 32'sd0, 32'sh80000000, 32'sd0));
    send_tick(mk_tick(32'sh80000000, 32'sh80000000, 32'sd0, 32'sh7fffffff, 32'sd0));
    // Yaw across the half turn is not wrapped, so this is a full-turn error.
    send_tick(mk_tick(32'sd0, 32'sd0, 32'sd205887, 32'sd0, -32'sd205887));
    send_tick(mk_tick(32'sd0, 32'sd0, 32'sh80000000, 32'sd0, 32'sh7fffffff));
    send_tick(mk_tick(32'sd0, 32'sd0, 32'sh7fffffff, 32'sd0, 32'sh80000000));
    // Small odd errors of both signs, where the rounding ties sit.
    send_tick(mk_tick(32'sd1, 32'sd0, 32'sd1, 32'sd0, 32'sd0));
    send_tick(mk_tick(-32'sd1, 32'sd0, -32'sd1, 32'sd0, 32'sd0));
    send_tick(mk_tick(32'sd3, 32'sd0, 32'sd128, 32'sd0, 32'sd0));
    send_tick(mk_tick(-32'sd3, 32'sd0, -32'sd128, 32'sd0, 32'sd0));
    // A steady ten-unit error drives each integral into its upper clamp, then the
    // opposite error drives it down into the lower one.
    for (n = 0; n < 4; n++) begin
      send_tick(mk_tick(32'sd655360, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
    end
    for (n = 0; n < 4; n++) begin
      send_tick(mk_tick(-32'sd655360, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
    end
    drain();
  endtask

  initial begin
    int p;
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    // Each phase takes a fresh register setting and one of the idling patterns; the
    // integrals and previous errors carry over from one phase into the next.
    for (p = 0; p < NumPhases; p++) begin
      case (p)
        1:       configure(CfgHigh);
        2:       configure(CfgLow);
        5:       configure(CfgNoIntegral);
        default: configure(CfgRandom);
      endcase
      set_idle(idle_mode_t'(p % 4));
      if (p % 4 == 0) begin
        hold_requests <= hold_requests + 1;
      end
      for (n = 0; n < ItemsPerPhase; n++) begin
        send_tick(rand_tick());
      end
      drain();
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pvc_pkg.sv
design/pvc_lane.sv
design/pvc_merge.sv
design/position_pid_yaw_pd_velocity_cmd.sv
design/pvc_checker.sv
tb/sv/tb_position_pid_yaw_pd_velocity_cmd.sv
